// ===== sv/aes_kx_pkg.sv =====
`default_nettype none

package aes_kx_pkg;

	localparam int KEY_W       = 64;
	localparam int ROUND_W     = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ROUND_W-1:0] FIRST_ROUND = 4'd0;
	localparam logic [ROUND_W-1:0] LAST_ROUND  = 4'd10;

	typedef struct packed {
		logic [KEY_W-1:0] key_high;
		logic [KEY_W-1:0] key_low;
	} key_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// round constant used to build round rnd+1 from round rnd
	function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] rnd);
		logic [7:0] c;
		case (rnd)
			4'd0:    c = 8'h01;
			4'd1:    c = 8'h02;
			4'd2:    c = 8'h04;
			4'd3:    c = 8'h08;
			4'd4:    c = 8'h10;
			4'd5:    c = 8'h20;
			4'd6:    c = 8'h40;
			4'd7:    c = 8'h80;
			4'd8:    c = 8'h1b;
			4'd9:    c = 8'h36;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic key_t next_round_key(input key_t k, input logic [ROUND_W-1:0] rnd);
		logic [31:0] w0, w1, w2, w3, rot, t;
		key_t n;
		w0  = k.key_high[63:32];
		w1  = k.key_high[31:0];
		w2  = k.key_low[63:32];
		w3  = k.key_low[31:0];
		rot = {w3[23:0], w3[31:24]};
		t   = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
		t   = t ^ {rcon(rnd), 24'h000000};
		w0  = w0 ^ t;
		w1  = w1 ^ w0;
		w2  = w2 ^ w1;
		w3  = w3 ^ w2;
		n.key_high = {w0, w1};
		n.key_low  = {w2, w3};
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== sv/aes_kx_if.sv =====
`default_nettype none

interface aes_kx_key_if;
	logic        valid;
	logic        ready;
	logic [63:0] key_high;
	logic [63:0] key_low;

	modport source (output valid, output key_high, output key_low, input ready);
	modport sink   (input valid, input key_high, input key_low, output ready);
endinterface

interface aes_kx_rk_if;
	logic        valid;
	logic        ready;
	logic [3:0]  round_number;
	logic [63:0] round_key_high;
	logic [63:0] round_key_low;
	logic        last_round;

	modport source (output valid, output round_number, output round_key_high,
		output round_key_low, output last_round, input ready);
	modport sink   (input valid, input round_number, input round_key_high,
		input round_key_low, input last_round, output ready);
endinterface

`default_nettype wire

// ===== sv/aes_kx_front.sv =====
`default_nettype none

module aes_kx_front #(
	parameter int Depth = aes_kx_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	aes_kx_key_if.sink           keys,
	output aes_kx_pkg::key_t     q_key,
	output logic                 q_valid,
	input  wire logic            q_ready
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	aes_kx_pkg::key_t mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign keys.ready = (count_q != CW'(Depth));
	assign q_valid    = (count_q != '0);
	assign q_key      = mem_q[rd_ptr_q];
	assign push       = keys.valid && keys.ready;
	assign pop        = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{key_high: keys.key_high, key_low: keys.key_low};
		end
	end

endmodule

`default_nettype wire

// ===== sv/aes_kx_back.sv =====
`default_nettype none

module aes_kx_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire aes_kx_pkg::key_t    q_key,
	input  wire logic                q_valid,
	output logic                     q_ready,
	aes_kx_rk_if.source              round_keys
);

	aes_kx_pkg::key_t                   key_q;
	aes_kx_pkg::key_t                   next_key;
	logic [aes_kx_pkg::ROUND_W-1:0]     round_q;
	logic                               valid_q;
	logic                               more_q;
	logic                               advance;

	// output register is free or being emptied this cycle
	assign advance  = !valid_q || round_keys.ready;
	assign q_ready  = advance && !more_q;
	assign next_key = aes_kx_pkg::next_round_key(key_q, round_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			more_q  <= 1'b0;
			round_q <= aes_kx_pkg::FIRST_ROUND;
		end else if (advance) begin
			if (more_q) begin
				valid_q <= 1'b1;
				round_q <= round_q + 4'd1;
				more_q  <= (round_q + 4'd1 != aes_kx_pkg::LAST_ROUND);
			end else if (q_valid) begin
				valid_q <= 1'b1;
				round_q <= aes_kx_pkg::FIRST_ROUND;
				more_q  <= 1'b1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (more_q) begin
				key_q <= next_key;
			end else if (q_valid) begin
				key_q <= q_key;
			end
		end
	end

	assign round_keys.valid          = valid_q;
	assign round_keys.round_number   = round_q;
	assign round_keys.round_key_high = key_q.key_high;
	assign round_keys.round_key_low  = key_q.key_low;
	assign round_keys.last_round     = (round_q == aes_kx_pkg::LAST_ROUND);

endmodule

`default_nettype wire

// ===== sv/aes128_key_expansion.sv =====
// aes-128 key expansion
// keys (sink): one item is a 128-bit cipher key as key_high / key_low,
//   byte 0 in key_high[63:56]
// round_keys (source): eleven items per key, rounds 0 to 10 in order, each
//   with round_number, round_key_high, round_key_low and last_round set on 10
// a key enters a small queue in the front part; the back part takes it from
// the queue and computes one round key per cycle into the output register,
// unless round_keys.ready stalls it; round 0 shows in the cycle after the
// key is taken, and rounds 1 to 10 follow in order
// keys are expanded one at a time by the single round unit, which produces
// one round key per cycle when not stalled; the queue takes the next key
// while the current one is still expanding
// stall: when round_keys.ready is low the output register holds its item and
// the round unit waits; keys are still taken until the queue is full
// reset: queue emptied, no item on the output, any run in progress is dropped
`default_nettype none

module aes128_key_expansion #(
	parameter int QueueDepth = aes_kx_pkg::QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	aes_kx_key_if.sink     keys,
	aes_kx_rk_if.source    round_keys
);

	aes_kx_pkg::key_t q_key;
	logic             q_valid;
	logic             q_ready;

	aes_kx_front #(
		.Depth (QueueDepth)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.keys    (keys),
		.q_key   (q_key),
		.q_valid (q_valid),
		.q_ready (q_ready)
	);

	aes_kx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_key      (q_key),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.round_keys (round_keys)
	);

endmodule

`default_nettype wire

// ===== sv/aes_kx_checker.sv =====
`default_nettype none

module aes_kx_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  round_number,
	input wire logic [63:0] round_key_high,
	input wire logic [63:0] round_key_low,
	input wire logic        last_round
);

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(round_number)
			&& $stable(round_key_high) && $stable(round_key_low))
		else $error("round key item changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_round == (round_number == 4'd10)))
		else $error("last marker does not match round number");

	// a run continues without a gap once started
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_round |=> out_valid)
		else $error("gap inside a run of round keys");

	a_next_round: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_round |=>
			round_number == $past(round_number) + 4'd1)
		else $error("round number did not step by one");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> round_number <= 4'd10)
		else $error("round number out of range");

endmodule

bind aes128_key_expansion aes_kx_checker u_aes_kx_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (round_keys.valid),
	.out_ready      (round_keys.ready),
	.round_number   (round_keys.round_number),
	.round_key_high (round_keys.round_key_high),
	.round_key_low  (round_keys.round_key_low),
	.last_round     (round_keys.last_round)
);

`default_nettype wire
